// ===== design/spcm_pkg.sv =====
// spcm_pkg: shared constants, codes and types of the spin pair correlation unit
// used by every module of the block; depends on nothing else
package spcm_pkg;

   localparam int MAX_SPINS     = 64;
   localparam int COUNT_BITS    = 16;
   localparam int IDX_BITS      = 6;
   localparam int SPIN_CNT_BITS = 7;
   localparam int SPINS_BITS    = 64;
   localparam int ADDR_BITS     = 2 * IDX_BITS;
   localparam int STORE_DEPTH   = 1 << ADDR_BITS;
   localparam int FRAC_BITS     = 14;
   localparam int QUOT_BITS     = FRAC_BITS + 1;
   localparam int STEP_BITS     = $clog2(QUOT_BITS);
   localparam int VALUE_BITS    = 16;

   localparam logic [COUNT_BITS-1:0]    COUNT_MAX        = {COUNT_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0]    ONE_Q14          = VALUE_BITS'(1 << FRAC_BITS);
   localparam logic [SPIN_CNT_BITS-1:0] SPIN_COUNT_RESET = SPIN_CNT_BITS'(64);
   localparam logic [SPIN_CNT_BITS-1:0] MAX_SPINS_CNT    = SPIN_CNT_BITS'(MAX_SPINS);

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_RD_WAIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [SPINS_BITS-1:0] spins;
      logic [IDX_BITS-1:0]   row;
      logic [IDX_BITS-1:0]   col;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         index_error;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [COUNT_BITS-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

endpackage

// ===== design/spcm_counter_ram.sv =====
// spcm_counter_ram: pair counter store, one write port and one registered read port
// depends on spcm_pkg
module spcm_counter_ram (
   input  logic                                clock,
   input  spcm_pkg::ram_wr_type                wr,
   input  logic [spcm_pkg::ADDR_BITS-1:0]      rd_addr,
   output logic [spcm_pkg::COUNT_BITS-1:0]     rd_data
);

   logic [spcm_pkg::COUNT_BITS-1:0] mem_ff [spcm_pkg::STORE_DEPTH];
   logic [spcm_pkg::COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/spcm_divider.sv =====
// spcm_divider: bit-serial fraction divider, one quotient bit per cycle
// depends on spcm_pkg; dividend must not exceed divisor
module spcm_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  spcm_pkg::div_req_type               div_req,
   output logic                                done,
   output logic [spcm_pkg::QUOT_BITS-1:0]      quotient
);

   localparam int CB = spcm_pkg::COUNT_BITS;
   localparam int QB = spcm_pkg::QUOT_BITS;
   localparam int SB = spcm_pkg::STEP_BITS;

   logic [CB:0]   rem_ff, rem_in;
   logic [CB-1:0] dvs_ff, dvs_in;
   logic [QB-1:0] quot_ff, quot_in;
   logic [SB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CB+1:0] diff;
   logic          ge;
   logic [CB:0]   rem_next;

   always_comb begin
      diff     = {1'b0, rem_ff} - {2'b00, dvs_ff};
      ge       = ~diff[CB+1];
      rem_next = ge ? diff[CB:0] : rem_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in  = {1'b0, div_req.dividend};
         dvs_in  = div_req.divisor;
         quot_in = '0;
         cnt_in  = SB'(QB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rem_next[CB-1:0], 1'b0};
         quot_in = {quot_ff[QB-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== design/spin_pair_correlation_matrix_unit.sv =====
// spin_pair_correlation_matrix_unit: top level, sequencer for clear, add and read items
// depends on spcm_pkg, spcm_counter_ram and spcm_divider
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes clear, add and read items.
//   rsp channel (rsp_valid/rsp_ready/rsp_item) returns one item per read.
//   csr_we/csr_wdata write spin_count while the block is idle.
// Item handling, n = active spins:
//   clear: all 4096 counter words are zeroed, one counter word written per cycle.
//   add: per pair of the n spins, one counter ram read and, when the pair agrees,
//   a write of the count plus one unless it is full; no pair is visited when fewer
//   than two spins are in use or the sample count is full.
//   read: uses the serial 15-step divider; out-of-range, diagonal, empty reads skip it.
//   one item is worked on at a time; req_ready is low while it runs.
// Reset: runs the same clearing pass over the counter ram with req_ready low;
//   spin_count returns to 64 and the sample count to zero.
// Stall: a result waits in the output register while the next item is taken;
//   a following read holds its result until the register is free.
module spin_pair_correlation_matrix_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  spcm_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output spcm_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_we,
   input  logic [spcm_pkg::SPIN_CNT_BITS-1:0]    csr_wdata
);

   localparam int CB = spcm_pkg::COUNT_BITS;
   localparam int NB = spcm_pkg::SPIN_CNT_BITS;
   localparam int IB = spcm_pkg::IDX_BITS;
   localparam int AB = spcm_pkg::ADDR_BITS;
   localparam int VB = spcm_pkg::VALUE_BITS;

   spcm_pkg::state_type   state_ff, state_in;
   logic [NB-1:0]         spin_count_ff, spin_count_in;
   logic [CB-1:0]         sample_ff, sample_in;
   logic [AB-1:0]         clr_ff, clr_in;
   logic [NB-1:0]         i_ff, i_in;
   logic [NB-1:0]         j_ff, j_in;
   logic [spcm_pkg::SPINS_BITS-1:0] spins_ff, spins_in;
   logic                  pend_ff, pend_in;
   logic                  agree_ff, agree_in;
   logic [AB-1:0]         wr_addr_ff, wr_addr_in;
   logic                  neg_ff, neg_in;
   spcm_pkg::rsp_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spcm_pkg::rsp_type     rsp_item_ff, rsp_item_in;

   logic [NB-1:0]         n_eff;
   logic                  accept;
   logic [IB-1:0]         lo_idx, hi_idx;
   logic [AB-1:0]         rd_addr;
   logic [CB-1:0]         rd_data;
   spcm_pkg::ram_wr_type  ram_wr;
   spcm_pkg::div_req_type div_req;
   logic                  div_done;
   logic [spcm_pkg::QUOT_BITS-1:0] quotient;
   logic [CB:0]           a2, n_ext;
   logic [VB-1:0]         q_ext;

   spcm_counter_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spcm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   assign n_eff     = (spin_count_ff > spcm_pkg::MAX_SPINS_CNT) ? spcm_pkg::MAX_SPINS_CNT
                                                                : spin_count_ff;
   assign req_ready = (state_ff == spcm_pkg::ST_IDLE) && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign lo_idx    = (req_item.row < req_item.col) ? req_item.row : req_item.col;
   assign hi_idx    = (req_item.row < req_item.col) ? req_item.col : req_item.row;
   assign a2        = {rd_data, 1'b0};
   assign n_ext     = {1'b0, sample_ff};
   assign q_ext     = VB'(quotient);

   always_comb begin
      state_in      = state_ff;
      spin_count_in = csr_we ? csr_wdata : spin_count_ff;
      sample_in     = sample_ff;
      clr_in        = clr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      spins_in      = spins_ff;
      pend_in       = 1'b0;
      agree_in      = agree_ff;
      wr_addr_in    = wr_addr_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      rd_addr       = {lo_idx, hi_idx};
      div_req       = '0;

      // write stage of the add pass, or the clearing sweep
      ram_wr.en   = pend_ff && agree_ff && (rd_data != spcm_pkg::COUNT_MAX);
      ram_wr.addr = wr_addr_ff;
      ram_wr.data = rd_data + 1'b1;

      unique case (state_ff)
         spcm_pkg::ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_ff;
            ram_wr.data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = spcm_pkg::ST_IDLE;
            end
         end
         spcm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_item.func)
                  spcm_pkg::FUNC_CLEAR: begin
                     sample_in = '0;
                     clr_in    = '0;
                     state_in  = spcm_pkg::ST_CLEAR;
                  end
                  spcm_pkg::FUNC_ADD: begin
                     if (sample_ff != spcm_pkg::COUNT_MAX) begin
                        sample_in = sample_ff + 1'b1;
                        spins_in  = req_item.spins;
                        i_in      = '0;
                        j_in      = NB'(1);
                        if (n_eff >= NB'(2)) begin
                           state_in = spcm_pkg::ST_ADD;
                        end
                     end
                  end
                  spcm_pkg::FUNC_READ: begin
                     res_in.value       = '0;
                     res_in.index_error = 1'b0;
                     state_in           = spcm_pkg::ST_FINISH;
                     if (({1'b0, req_item.row} >= n_eff) ||
                         ({1'b0, req_item.col} >= n_eff)) begin
                        res_in.index_error = 1'b1;
                     end else if (req_item.row == req_item.col) begin
                        res_in.value = spcm_pkg::ONE_Q14;
                     end else if (sample_ff != '0) begin
                        state_in = spcm_pkg::ST_RD_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spcm_pkg::ST_ADD: begin
            rd_addr    = {i_ff[IB-1:0], j_ff[IB-1:0]};
            pend_in    = 1'b1;
            agree_in   = spins_ff[i_ff[IB-1:0]] == spins_ff[j_ff[IB-1:0]];
            wr_addr_in = {i_ff[IB-1:0], j_ff[IB-1:0]};
            if ((j_ff + 1'b1) < n_eff) begin
               j_in = j_ff + 1'b1;
            end else if ((i_ff + NB'(2)) < n_eff) begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + NB'(2);
            end else begin
               state_in = spcm_pkg::ST_IDLE;
            end
         end
         spcm_pkg::ST_RD_WAIT: begin
            div_req.start   = 1'b1;
            div_req.divisor = sample_ff;
            if (a2 >= n_ext) begin
               div_req.dividend = CB'(a2 - n_ext);
               neg_in           = 1'b0;
            end else begin
               div_req.dividend = CB'(n_ext - a2);
               neg_in           = 1'b1;
            end
            state_in = spcm_pkg::ST_DIV;
         end
         spcm_pkg::ST_DIV: begin
            if (div_done) begin
               res_in.value       = neg_ff ? (~q_ext + 1'b1) : q_ext;
               res_in.index_error = 1'b0;
               state_in           = spcm_pkg::ST_FINISH;
            end
         end
         spcm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = spcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spcm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spcm_pkg::ST_CLEAR;
         spin_count_ff <= spcm_pkg::SPIN_COUNT_RESET;
         sample_ff     <= '0;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spin_count_ff <= spin_count_in;
         sample_ff     <= sample_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      spins_ff    <= spins_in;
      agree_ff    <= agree_in;
      wr_addr_ff  <= wr_addr_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== design/spcm_checker.sv =====
// spcm_checker: port-level assertions for spin_pair_correlation_matrix_unit
// depends on spcm_pkg; bound to the top level at the end of this file
module spcm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input spcm_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input spcm_pkg::rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.index_error |-> rsp_item.value == '0)
      else $error("index error item with nonzero value");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_item.value) <= $signed(spcm_pkg::ONE_Q14)) &&
                    ($signed(rsp_item.value) >= -$signed(spcm_pkg::ONE_Q14)))
      else $error("result value outside of one");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result right after reset");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.func == spcm_pkg::FUNC_CLEAR) |=> !req_ready)
      else $error("item taken during clearing pass");

endmodule

bind spin_pair_correlation_matrix_unit spcm_checker u_spcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ===== sim/tb_spin_pair_correlation_matrix_unit.sv =====
// tb_spin_pair_correlation_matrix_unit: self-checking bench for the spin pair correlation unit
// predicts every read result from its own copy of the pair counters, sample count and spin count
// depends on spcm_pkg and spin_pair_correlation_matrix_unit
module tb_spin_pair_correlation_matrix_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 4200;
   localparam int STALL_LIMIT = 20000;
   localparam int SIDE = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   spcm_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   spcm_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [spcm_pkg::SPIN_CNT_BITS-1:0] csr_wdata = '0;

   spcm_pkg::req_type spin_items[$];
   spcm_pkg::rsp_type due_correlations[$];
   logic [spcm_pkg::COUNT_BITS-1:0] agree_tally [spcm_pkg::STORE_DEPTH];
   logic [spcm_pkg::COUNT_BITS-1:0] sample_tally = '0;
   int spins_in_use = 64;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int fail_count = 0;
   bit steady = 1'b0;

   spin_pair_correlation_matrix_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_spins();
      return (spins_in_use > spcm_pkg::MAX_SPINS) ? spcm_pkg::MAX_SPINS : spins_in_use;
   endfunction

   function automatic spcm_pkg::req_type make_item(logic [1:0] f,
                                                   logic [spcm_pkg::SPINS_BITS-1:0] s,
                                                   int r, int c);
      spcm_pkg::req_type it;
      it.func = f;
      it.spins = s;
      it.row = spcm_pkg::IDX_BITS'(r);
      it.col = spcm_pkg::IDX_BITS'(c);
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic spcm_pkg::req_type random_spin_item(int n);
      int pick;
      logic [1:0] f;
      logic [spcm_pkg::SPINS_BITS-1:0] s;
      int r;
      int c;
      pick = $urandom_range(0, 99);
      s = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: s = '0;
         1: s = '1;
         2: s = s & {$urandom, $urandom};
         default: ;
      endcase
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
      if (n > 0 && $urandom_range(0, 9) < 8) begin
         r = $urandom_range(0, n - 1);
         c = $urandom_range(0, n - 1);
      end
      if ($urandom_range(0, 9) == 0) c = r;
      if (pick < 3) f = spcm_pkg::FUNC_CLEAR;
      else if (pick < 8) f = FUNC_UNUSED;
      else if (pick < 50) f = spcm_pkg::FUNC_ADD;
      else f = spcm_pkg::FUNC_READ;
      return make_item(f, s, r, c);
   endfunction

   // updates the pair counters and queues the expected read result
   function automatic void predict_correlation(spcm_pkg::req_type it);
      int n;
      int lo;
      int hi;
      longint tally2;
      longint total;
      longint q;
      spcm_pkg::rsp_type want;
      n = active_spins();
      case (it.func)
         spcm_pkg::FUNC_CLEAR: begin
            foreach (agree_tally[k]) agree_tally[k] = '0;
            sample_tally = '0;
         end
         spcm_pkg::FUNC_ADD: begin
            if (sample_tally != spcm_pkg::COUNT_MAX) begin
               for (int i = 0; i < n; i++)
                  for (int j = i + 1; j < n; j++)
                     if (it.spins[i] == it.spins[j] &&
                         agree_tally[i*SIDE+j] != spcm_pkg::COUNT_MAX)
                        agree_tally[i*SIDE+j] = agree_tally[i*SIDE+j] + 1'b1;
               sample_tally = sample_tally + 1'b1;
            end
         end
         spcm_pkg::FUNC_READ: begin
            want = '0;
            if (it.row >= n || it.col >= n) begin
               want.index_error = 1'b1;
            end else if (it.row == it.col) begin
               want.value = spcm_pkg::ONE_Q14;
            end else if (sample_tally != 0) begin
               lo = (it.row < it.col) ? it.row : it.col;
               hi = (it.row < it.col) ? it.col : it.row;
               total = sample_tally;
               tally2 = 2 * longint'(agree_tally[lo*SIDE+hi]);
               q = (((tally2 >= total) ? tally2 - total : total - tally2) * 16384) / total;
               if (tally2 < total) q = -q;
               want.value = spcm_pkg::VALUE_BITS'(q);
            end
            due_correlations.push_back(want);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) predict_correlation(req_item);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (spin_items.size() != 0) begin
               req_valid <= 1'b1;
               req_item <= spin_items.pop_front();
               gap_left <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      spcm_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_correlations.size() == 0) begin
               report_mismatch("unexpected item, value", int'(rsp_item.value), 0);
            end else begin
               want = due_correlations.pop_front();
               if (rsp_item.value !== want.value)
                  report_mismatch("value", int'(rsp_item.value), int'(want.value));
               if (rsp_item.index_error !== want.index_error)
                  report_mismatch("index_error", int'(rsp_item.index_error),
                                  int'(want.index_error));
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (spin_items.size() != 0 || req_valid || due_correlations.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_spin_count(input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= spcm_pkg::SPIN_CNT_BITS'(v);
      spins_in_use = v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int spin_settings[11];
      foreach (agree_tally[k]) agree_tally[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty reads, mixed adds, symmetry, unused code, clear
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '1, 2, 9));
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, '1, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, '0, 63, 63));
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 1));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 1, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 2));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 63, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 63, 63));
      spin_items.push_back(make_item(FUNC_UNUSED, '1, 0, 1));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 62, 63));
      spin_items.push_back(make_item(spcm_pkg::FUNC_CLEAR, '1, 63, 63));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 1));
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, 64'h8000_0000_0000_0001, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 63));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 1, 0));
      settle();

      // no spin in use, then a narrow setting over the old counters
      write_spin_count(0);
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, 64'h0123_4567_89AB_CDEF, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 63, 63));
      settle();
      write_spin_count(3);
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 3, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 3));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 2, 1));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 2, 2));
      settle();
      write_spin_count(64);
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 1));
      settle();

      spin_settings = '{1, 2, 3, 7, 13, 32, 63, 64, 100, 127, 0};
      spin_settings[10] = $urandom_range(0, 127);
      foreach (spin_settings[k]) begin
         write_spin_count(spin_settings[k]);
         steady = ($urandom_range(0, 3) == 0);
         repeat (24) spin_items.push_back(random_spin_item(active_spins()));
         settle();
      end

      write_spin_count(64);
      steady = 1'b0;
      spin_items.push_back(make_item(spcm_pkg::FUNC_ADD, '1, 0, 0));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 0, 1));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 5, 40));
      spin_items.push_back(make_item(spcm_pkg::FUNC_READ, '0, 63, 62));
      settle();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
